>>> sv/two_button_press_classifier_assert.svh
// Assertion macros shared by the two-button press classifier modules.
`ifndef TWO_BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define TWO_BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TBPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tbpc assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define TBPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tbpc assertion failed");

`endif

>>> sv/tbpc_pkg.sv
// Shared types and constants of the two-button press classifier.
package tbpc_pkg;

  localparam int unsigned IntegWidth = 10;
  localparam int unsigned ThrWidth   = 16;
  localparam int unsigned CfgWidth   = 16;

  // Item kinds.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // Configuration register indexes.
  localparam logic REG_INTEG_MAX = 1'b0;
  localparam logic REG_LONG_THR  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [IntegWidth-1:0] INTEG_MAX_RST = 10'd8;
  localparam logic [ThrWidth-1:0]   LONG_THR_RST  = 16'd100;

  // One result item.
  typedef struct packed {
    logic short_a;
    logic short_b;
    logic long_a;
    logic long_b;
    logic double_short;
  } tbpc_result_t;

endpackage

>>> sv/tbpc_debounce.sv
// Up/down saturating integrator that debounces one active-low button level.
module tbpc_debounce import tbpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  level_i,
  input  logic [IntegWidth-1:0] integ_max_i,
  output logic                  clean_o
);

  logic [IntegWidth-1:0] integ_q, integ_d;
  logic                  clean_q, clean_d;

  // Step the integrator toward the raw level, then clamp and decide the level.
  always_comb begin
    integ_d = integ_q;
    clean_d = clean_q;
    if (level_i == 1'b0) begin
      if (integ_q != '0) integ_d = integ_q - 1'b1;
    end else if (integ_q < integ_max_i) begin
      integ_d = integ_q + 1'b1;
    end
    if (integ_d == '0) begin
      clean_d = 1'b0;
    end else if (integ_d >= integ_max_i) begin
      clean_d = 1'b1;
      integ_d = integ_max_i;
    end
  end

  // The new level is used by the same poll that produced it.
  assign clean_o = clean_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      clean_q <= 1'b1;
    end else if (en_i) begin
      integ_q <= integ_d;
      clean_q <= clean_d;
    end
  end

endmodule

>>> sv/tbpc_classify.sv
// Shared press timer and per-button press flags that classify each poll.
module tbpc_classify import tbpc_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_i,
  input  logic                poll_i,
  input  logic                clean_a_i,
  input  logic                clean_b_i,
  input  logic [ThrWidth-1:0] long_thr_i,
  output tbpc_result_t        result_o
);

  `include "two_button_press_classifier_assert.svh"

  localparam int unsigned CmpWidth = (TIMER_WIDTH > ThrWidth) ? TIMER_WIDTH : ThrWidth;

  logic [TIMER_WIDTH-1:0] timer_q, timer_d;
  logic [1:0]             armed_q, armed_d;
  logic [1:0]             lready_q, lready_d;
  logic [1:0]             lock_q, lock_d;
  logic [1:0]             pend_q, pend_d;
  logic                   dseen_q, dseen_d;
  tbpc_result_t           res;

  // Tick: advance the timer. Poll: serve button A, then button B.
  always_comb begin
    timer_d  = timer_q;
    armed_d  = armed_q;
    lready_d = lready_q;
    lock_d   = lock_q;
    pend_d   = pend_q;
    dseen_d  = dseen_q;
    res      = '0;

    if (tick_i) begin
      if (timer_q != '1) timer_d = timer_q + 1'b1;
      if (CmpWidth'(timer_d) > CmpWidth'(long_thr_i)) lready_d = lready_q | armed_q;
    end

    if (poll_i) begin
      // Button A: arm before the long check.
      if (clean_a_i == 1'b0) begin
        if (!lock_d[0]) begin
          if (!armed_d[0]) begin
            timer_d    = '0;
            armed_d[0] = 1'b1;
            pend_d[0]  = 1'b1;
          end
          if (lready_d[0]) begin
            if (!dseen_d) res.long_a = 1'b1;
            lock_d[0] = 1'b1;
            pend_d[0] = 1'b0;
          end
        end
      end else begin
        if (pend_d[0]) begin
          if (pend_d[1] && !dseen_d) begin
            dseen_d          = 1'b1;
            res.double_short = 1'b1;
          end else if (!dseen_d) begin
            res.short_a = 1'b1;
          end else begin
            pend_d  = 2'b00;
            dseen_d = 1'b0;
          end
          pend_d[0] = 1'b0;
        end
        lready_d[0] = 1'b0;
        armed_d[0]  = 1'b0;
        lock_d[0]   = 1'b0;
      end

      // Button B: long check before arm.
      if (clean_b_i == 1'b0) begin
        if (!lock_d[1]) begin
          if (lready_d[1]) begin
            if (!dseen_d) res.long_b = 1'b1;
            lock_d[1] = 1'b1;
            pend_d[1] = 1'b0;
          end
          if (!armed_d[1]) begin
            timer_d    = '0;
            armed_d[1] = 1'b1;
            pend_d[1]  = 1'b1;
          end
        end
      end else begin
        if (pend_d[1]) begin
          if (pend_d[0] && !dseen_d) begin
            dseen_d          = 1'b1;
            res.double_short = 1'b1;
          end else if (!dseen_d) begin
            res.short_b = 1'b1;
          end else begin
            pend_d  = 2'b00;
            dseen_d = 1'b0;
          end
          pend_d[1] = 1'b0;
        end
        lready_d[1] = 1'b0;
        armed_d[1]  = 1'b0;
        lock_d[1]   = 1'b0;
      end
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q  <= '0;
      armed_q  <= '0;
      lready_q <= '0;
      lock_q   <= '0;
      pend_q   <= '0;
      dseen_q  <= 1'b0;
    end else begin
      timer_q  <= timer_d;
      armed_q  <= armed_d;
      lready_q <= lready_d;
      lock_q   <= lock_d;
      pend_q   <= pend_d;
      dseen_q  <= dseen_d;
    end
  end

  // A long mark or a lockout only exists while its button is armed.
  `TBPC_ASSERT_NOW(a_lready_a_armed, lready_q[0], armed_q[0])
  `TBPC_ASSERT_NOW(a_lready_b_armed, lready_q[1], armed_q[1])
  `TBPC_ASSERT_NOW(a_lock_armed, (lock_q & ~armed_q) != 2'b00, 1'b0)

endmodule

>>> sv/two_button_press_classifier.sv
// Top level of the two-button press classifier: handshake, configuration and result registers.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | input     | in_valid_i/in_ready_o  | cmd_i, level_a_i, level_b_i
//  out     | output    | out_valid_o/out_ready_i| short_a_o, short_b_o, long_a_o,
//          |           |                        | long_b_o, double_short_o
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// An item is registered on acceptance and classified from the input register; a poll's result
// is then registered in the output register.
// One item is accepted per cycle unless a poll waits; the input and output registers set it.
// A tick produces no result and never waits on the output side.
// A poll waits in the input register only while a result is held by out_ready_i low.
// Reset restores the configuration to its reset values and clears all press state.
module two_button_press_classifier import tbpc_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic                level_a_i,
  input  logic                level_b_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                short_a_o,
  output logic                short_b_o,
  output logic                long_a_o,
  output logic                long_b_o,
  output logic                double_short_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i
);

  `include "two_button_press_classifier_assert.svh"

  logic [IntegWidth-1:0] integ_max_q;
  logic [ThrWidth-1:0]   long_thr_q;
  logic                  in_valid_q;
  logic                  cmd_q, level_a_q, level_b_q;
  logic                  out_valid_q;
  tbpc_result_t          out_q, result;
  logic                  advance, tick, poll;
  logic                  clean_a, clean_b;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_max_q <= INTEG_MAX_RST;
      long_thr_q  <= LONG_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INTEG_MAX: integ_max_q <= cfg_wdata_i[IntegWidth-1:0];
        REG_LONG_THR:  long_thr_q  <= cfg_wdata_i[ThrWidth-1:0];
        default:       ;
      endcase
    end
  end

  // The held item moves on unless it is a poll facing a full, stalled output.
  assign advance    = in_valid_q && (cmd_q == CMD_TICK || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign tick       = advance && (cmd_q == CMD_TICK);
  assign poll       = advance && (cmd_q == CMD_POLL);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q     <= cmd_i;
      level_a_q <= level_a_i;
      level_b_q <= level_b_i;
    end
  end

  tbpc_debounce u_deb_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (poll),
    .level_i     (level_a_q),
    .integ_max_i (integ_max_q),
    .clean_o     (clean_a)
  );

  tbpc_debounce u_deb_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (poll),
    .level_i     (level_b_q),
    .integ_max_i (integ_max_q),
    .clean_o     (clean_b)
  );

  tbpc_classify #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_classify (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .poll_i     (poll),
    .clean_a_i  (clean_a),
    .clean_b_i  (clean_b),
    .long_thr_i (long_thr_q),
    .result_o   (result)
  );

  // Output register: loaded by each poll, emptied when the item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (poll) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll) out_q <= result;
  end

  assign out_valid_o    = out_valid_q;
  assign short_a_o      = out_q.short_a;
  assign short_b_o      = out_q.short_b;
  assign long_a_o       = out_q.long_a;
  assign long_b_o       = out_q.long_b;
  assign double_short_o = out_q.double_short;

  // Every classified poll leaves a result behind.
  `TBPC_ASSERT_NEXT(a_poll_gives_result, poll, out_valid_q)
  // A poll never overwrites a result that is still stalled.
  `TBPC_ASSERT_NOW(a_no_overwrite, out_valid_q && !out_ready_i, !poll)
  // A double press is never reported together with a single short press.
  `TBPC_ASSERT_NOW(a_double_excl, out_valid_q && out_q.double_short,
                   !out_q.short_a && !out_q.short_b)

endmodule
